// ===== rtl/sctm_pkg.sv =====
`default_nettype none

package sctm_pkg;

   // line buffer geometry
   localparam int LINE_LEN = 32;
   localparam int LINE_AW  = $clog2(LINE_LEN);

   // command table geometry
   localparam int MAX_COMMANDS = 16;
   localparam int CMD_AW       = $clog2(MAX_COMMANDS);
   localparam int ENTRY_LEN    = 32;
   localparam int ENTRY_AW     = $clog2(ENTRY_LEN);

   // field widths
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // request kinds
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_FILL    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_MATCH   = 2'd2;

   // register indexes
   localparam logic CSR_TERMINATOR    = 1'b0;
   localparam logic CSR_COMMAND_COUNT = 1'b1;

   // fixed characters
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_FIRST = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7E;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MATCH,
      ST_HOLD
   } st_type;

endpackage

`default_nettype wire

// ===== rtl/serial_command_token_matcher.sv =====
`default_nettype none
// character and table-load requests: result registered at acceptance, or parked while the
// output register is occupied; one per cycle while the output is free; terminator request:
// line scan, then table entries compared in turn (one table read per cycle, one read in
// flight); the block takes no request from acceptance until the scan and compare finish
// synchronous active-high reset clears the line buffer, write position and sequencer,
// sets terminator to 0x23 and command count to 0; the command table is not cleared
module serial_command_token_matcher (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [0:0] req_tuser,   // [0] op
   input  wire [23:0] req_tdata,   // [7:0] char_value, [11:8] entry_index, [16:12] char_pos
   // result channel
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [1:0] status, [5:2] match_index
   // configuration writes
   input  wire        csr_we,
   input  wire        csr_addr,
   input  wire  [7:0] csr_wdata
);

   localparam int CW = sctm_pkg::CHAR_W;
   localparam int LW = sctm_pkg::LINE_AW;
   localparam int EW = sctm_pkg::ENTRY_AW;
   localparam int KW = sctm_pkg::CMD_AW;
   localparam int SW = sctm_pkg::STATUS_W;
   localparam int NW = sctm_pkg::COUNT_W;

   localparam logic [EW-1:0] ENTRY_LAST_C = EW'(sctm_pkg::ENTRY_LEN - 1);
   localparam logic [NW-1:0] MAX_CMD_C    = NW'(sctm_pkg::MAX_COMMANDS);

   // request fields
   logic          in_op;
   logic [CW-1:0] in_char;
   logic [KW-1:0] in_entry;
   logic [EW-1:0] in_pos;
   assign in_op    = req_tuser[0];
   assign in_char  = req_tdata[7:0];
   assign in_entry = req_tdata[11:8];
   assign in_pos   = req_tdata[16:12];

   // registers
   sctm_pkg::st_type state_ff, state_in;
   logic [CW-1:0] line_ff [sctm_pkg::LINE_LEN];
   logic [CW-1:0] line_in [sctm_pkg::LINE_LEN];
   logic [LW-1:0] wr_pos_ff, wr_pos_in;
   logic [CW-1:0] term_ff;
   logic [NW-1:0] cmd_count_ff;
   logic [LW:0]   scan_idx_ff, scan_idx_in;
   logic [LW:0]   skip_cnt_ff, skip_cnt_in;
   logic          skip_run_ff, skip_run_in;
   logic          s_run_ff, s_run_in;
   logic          tok_run_ff, tok_run_in;
   logic [LW:0]   tok_start_ff, tok_start_in;
   logic [LW:0]   tok_end_ff, tok_end_in;
   logic [KW-1:0] entry_ff, entry_in;
   logic [EW-1:0] rd_idx_ff, rd_idx_in;
   logic [EW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [CW-1:0] tbl_q_ff;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;
   logic [KW-1:0] rsp_index_ff, rsp_index_in;
   logic [SW-1:0] hold_status_ff, hold_status_in;
   logic [KW-1:0] hold_index_ff, hold_index_in;

   // command table memory
   logic [CW-1:0] tbl_mem [sctm_pkg::MAX_COMMANDS * sctm_pkg::ENTRY_LEN];

   // shared signals
   logic          req_fire;
   logic          out_free;
   logic [LW-1:0] line_rd_addr;
   logic [CW-1:0] line_rd;
   logic [LW:0]   match_pos;
   logic [CW-1:0] a_char;
   logic          chars_eq;
   logic          scan_end;
   logic          c_skip;
   logic          c_delim;
   logic [NW-1:0] n_eff;
   logic          last_entry;
   logic          term_printable;
   logic          res_go;
   logic [SW-1:0] res_status;
   logic [KW-1:0] res_index;
   logic          go_scan;
   logic          go_match;
   logic          finish;

   function automatic logic is_printable(input logic [CW-1:0] c);
      return (c >= sctm_pkg::CH_FIRST) && (c <= sctm_pkg::CH_LAST);
   endfunction

   assign req_tready = (state_ff == sctm_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_index_ff, rsp_status_ff};

   // one line buffer read port, shared by scan and compare
   assign match_pos    = tok_start_ff + {1'b0, cmp_idx_ff};
   assign line_rd_addr = (state_ff == sctm_pkg::ST_SCAN) ? scan_idx_ff[LW-1:0]
                                                          : match_pos[LW-1:0];
   assign line_rd      = line_ff[line_rd_addr];

   // character classes of the scanned character
   assign c_skip  = (line_rd == sctm_pkg::CH_SPACE) || (line_rd == term_ff) ||
                    (line_rd == sctm_pkg::CH_LF) || (line_rd == sctm_pkg::CH_CR);
   assign c_delim = c_skip || (line_rd == sctm_pkg::CH_COMMA);
   assign scan_end = scan_idx_ff[LW] || (line_rd == '0);

   // token character against table character
   assign a_char   = (match_pos < tok_end_ff) ? line_rd : '0;
   assign chars_eq = (a_char == tbl_q_ff);

   assign n_eff      = (cmd_count_ff > MAX_CMD_C) ? MAX_CMD_C : cmd_count_ff;
   assign last_entry = (({1'b0, entry_ff} + NW'(1)) == n_eff);
   assign term_printable = is_printable(term_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff      <= 8'd35;
         cmd_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            sctm_pkg::CSR_TERMINATOR:    term_ff      <= csr_wdata;
            sctm_pkg::CSR_COMMAND_COUNT: cmd_count_ff <= csr_wdata[NW-1:0];
            default: ;
         endcase
      end
   end

   // command table: load writes, registered read for the compare
   always_ff @(posedge clock) begin
      if (req_fire && (in_op == sctm_pkg::OP_LOAD)) begin
         tbl_mem[{in_entry, in_pos}] <= in_char;
      end
      tbl_q_ff <= tbl_mem[{entry_ff, rd_idx_ff}];
   end

   // sequencer events
   always_comb begin
      res_go     = 1'b0;
      res_status = sctm_pkg::STAT_FILL;
      res_index  = '0;
      go_scan    = 1'b0;
      go_match   = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         sctm_pkg::ST_IDLE: begin
            if (req_fire) begin
               if ((in_op == sctm_pkg::OP_CHAR) && (in_char == term_ff)) begin
                  go_scan = 1'b1;
               end else begin
                  res_go = 1'b1;
               end
            end
         end
         sctm_pkg::ST_SCAN: begin
            if (scan_end) begin
               if (s_run_ff) begin
                  res_go = 1'b1;
               end else if (n_eff == '0) begin
                  res_go     = 1'b1;
                  res_status = sctm_pkg::STAT_UNKNOWN;
                  finish     = 1'b1;
               end else begin
                  go_match = 1'b1;
               end
            end
         end
         sctm_pkg::ST_MATCH: begin
            if (rd_valid_ff) begin
               if (!chars_eq) begin
                  if (last_entry) begin
                     res_go     = 1'b1;
                     res_status = sctm_pkg::STAT_UNKNOWN;
                     finish     = 1'b1;
                  end
               end else if ((a_char == '0) || (cmp_idx_ff == ENTRY_LAST_C)) begin
                  res_go     = 1'b1;
                  res_status = sctm_pkg::STAT_MATCH;
                  res_index  = entry_ff;
                  finish     = 1'b1;
               end
            end
         end
         sctm_pkg::ST_HOLD: ;
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sctm_pkg::ST_IDLE: begin
            if (go_scan) begin
               state_in = sctm_pkg::ST_SCAN;
            end else if (res_go && !out_free) begin
               state_in = sctm_pkg::ST_HOLD;
            end
         end
         sctm_pkg::ST_SCAN: begin
            if (go_match) begin
               state_in = sctm_pkg::ST_MATCH;
            end else if (res_go) begin
               state_in = out_free ? sctm_pkg::ST_IDLE : sctm_pkg::ST_HOLD;
            end
         end
         sctm_pkg::ST_MATCH: begin
            if (res_go) begin
               state_in = out_free ? sctm_pkg::ST_IDLE : sctm_pkg::ST_HOLD;
            end
         end
         sctm_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = sctm_pkg::ST_IDLE;
            end
         end
         default: state_in = sctm_pkg::ST_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      line_in        = line_ff;
      wr_pos_in      = wr_pos_ff;
      scan_idx_in    = scan_idx_ff;
      skip_cnt_in    = skip_cnt_ff;
      skip_run_in    = skip_run_ff;
      s_run_in       = s_run_ff;
      tok_run_in     = tok_run_ff;
      tok_start_in   = tok_start_ff;
      tok_end_in     = tok_end_ff;
      entry_in       = entry_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_idx_in     = cmp_idx_ff;
      rd_valid_in    = rd_valid_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      hold_status_in = hold_status_ff;
      hold_index_in  = hold_index_ff;

      unique case (state_ff)
         sctm_pkg::ST_IDLE: begin
            if (go_scan) begin
               scan_idx_in  = '0;
               skip_cnt_in  = '0;
               skip_run_in  = 1'b1;
               s_run_in     = 1'b1;
               tok_run_in   = 1'b0;
               tok_start_in = '0;
               tok_end_in   = '0;
            end else if (req_fire && (in_op == sctm_pkg::OP_CHAR) && is_printable(in_char)) begin
               // store and zero the following slot
               line_in[wr_pos_ff] = in_char;
               if (wr_pos_ff != LW'(sctm_pkg::LINE_LEN - 1)) begin
                  line_in[wr_pos_ff + LW'(1)] = '0;
               end
               wr_pos_in = wr_pos_ff + LW'(1);
            end
         end
         sctm_pkg::ST_SCAN: begin
            if (!scan_end) begin
               // one character per cycle: leading skip run, token start and end
               scan_idx_in = scan_idx_ff + (LW + 1)'(1);
               if (skip_run_ff) begin
                  if (c_skip) begin
                     skip_cnt_in = skip_cnt_ff + (LW + 1)'(1);
                  end else begin
                     skip_run_in = 1'b0;
                  end
               end
               if (s_run_ff) begin
                  if (!c_delim) begin
                     s_run_in     = 1'b0;
                     tok_run_in   = 1'b1;
                     tok_start_in = scan_idx_ff;
                  end
               end else if (tok_run_ff && c_delim) begin
                  tok_run_in = 1'b0;
                  tok_end_in = scan_idx_ff;
               end
            end else begin
               if (s_run_ff) begin
                  // line of delimiters only: buffer kept, position after skip run
                  wr_pos_in = skip_cnt_ff[LW-1:0];
               end
               if (tok_run_ff) begin
                  tok_end_in = scan_idx_ff;
               end
               entry_in    = '0;
               rd_idx_in   = '0;
               cmp_idx_in  = '0;
               rd_valid_in = 1'b0;
            end
         end
         sctm_pkg::ST_MATCH: begin
            // issue the next table read, compare the previous one
            rd_valid_in = 1'b1;
            cmp_idx_in  = rd_idx_ff;
            rd_idx_in   = rd_idx_ff + EW'(1);
            if (rd_valid_ff && !chars_eq && !last_entry) begin
               entry_in    = entry_ff + KW'(1);
               rd_idx_in   = '0;
               rd_valid_in = 1'b0;
            end
         end
         sctm_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = hold_status_ff;
               rsp_index_in  = hold_index_ff;
            end
         end
         default: ;
      endcase

      // clear the line after a command, then keep a printable terminator
      if (finish) begin
         for (int i = 0; i < sctm_pkg::LINE_LEN; i++) begin
            line_in[i] = '0;
         end
         if (term_printable) begin
            line_in[0] = term_ff;
            wr_pos_in  = LW'(1);
         end else begin
            wr_pos_in  = '0;
         end
      end

      // result to output register, or parked while it is occupied
      if (res_go) begin
         if (out_free) begin
            rsp_tvalid_in = 1'b1;
            rsp_status_in = res_status;
            rsp_index_in  = res_index;
         end else begin
            hold_status_in = res_status;
            hold_index_in  = res_index;
         end
      end
   end

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sctm_pkg::ST_IDLE;
         wr_pos_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         scan_idx_ff   <= '0;
         skip_run_ff   <= 1'b0;
         s_run_ff      <= 1'b0;
         tok_run_ff    <= 1'b0;
         entry_ff      <= '0;
         rd_idx_ff     <= '0;
         cmp_idx_ff    <= '0;
         for (int i = 0; i < sctm_pkg::LINE_LEN; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         wr_pos_ff     <= wr_pos_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rd_valid_ff   <= rd_valid_in;
         scan_idx_ff   <= scan_idx_in;
         skip_run_ff   <= skip_run_in;
         s_run_ff      <= s_run_in;
         tok_run_ff    <= tok_run_in;
         entry_ff      <= entry_in;
         rd_idx_ff     <= rd_idx_in;
         cmp_idx_ff    <= cmp_idx_in;
         line_ff       <= line_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      skip_cnt_ff    <= skip_cnt_in;
      tok_start_ff   <= tok_start_in;
      tok_end_ff     <= tok_end_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      hold_status_ff <= hold_status_in;
      hold_index_ff  <= hold_index_in;
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int          CHAR_W       = sctm_pkg::CHAR_W;
   localparam int          CMD_AW       = sctm_pkg::CMD_AW;
   localparam int          ENTRY_AW     = sctm_pkg::ENTRY_AW;
   localparam int          STATUS_W     = sctm_pkg::STATUS_W;
   localparam int          COUNT_W      = sctm_pkg::COUNT_W;
   localparam int          LINE_LEN     = sctm_pkg::LINE_LEN;
   localparam int          MAX_COMMANDS = sctm_pkg::MAX_COMMANDS;
   localparam int          ENTRY_LEN    = sctm_pkg::ENTRY_LEN;

   localparam int          CYCLE_LIMIT  = 5_000_000;
   localparam int          N_PHASES     = 7;
   localparam int          PHASE_ITEMS  = 60;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 600;
   localparam int          N_DIRECTED   = 22;
   localparam logic [7:0]  TERM_RESET   = 8'h23;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CMD_AW-1:0]   match_index;
   } verdict_type;

   typedef struct packed {
      logic                op;
      logic [CHAR_W-1:0]   ch;
      logic [CMD_AW-1:0]   ent;
      logic [ENTRY_AW-1:0] pos;
      logic                known;
      verdict_type         want;
   } directed_row_type;

   localparam verdict_type FILL_V    = '{sctm_pkg::STAT_FILL, 4'd0};
   localparam verdict_type UNKNOWN_V = '{sctm_pkg::STAT_UNKNOWN, 4'd0};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser  = 1'b0;
   logic [23:0] req_tdata  = 24'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [7:0]  csr_wdata  = 8'd0;

   // stimulus shaping
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_armed    = 1'b0;
   logic rsp_hold     = 1'b0;

   // bookkeeping
   int  cycle_count    = 0;
   int  mismatch_count = 0;
   int  request_count  = 0;
   int  match_count    = 0;
   int  unknown_count  = 0;
   verdict_type verdict_q [$];

   // shadow of the block state
   logic [CHAR_W-1:0] line_buf [LINE_LEN];
   int unsigned       wr_pos;
   logic [CHAR_W-1:0] cmd_table [MAX_COMMANDS][ENTRY_LEN];
   logic [CHAR_W-1:0] term_char;
   int unsigned       cmd_count;

   // per-phase settings, the extremes among them
   logic [7:0] phase_term [N_PHASES] = '{8'h23, 8'h00, 8'hFF, 8'h3B, 8'h20, 8'h0A, 8'h2E};
   logic [7:0] phase_count [N_PHASES] = '{8'd16, 8'd1, 8'd8, 8'd31, 8'd0, 8'd16, 8'd12};

   // directed requests, typed expectations where obvious
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{sctm_pkg::OP_CHAR, 8'h61, 4'd0,  5'd0,  1'b1, FILL_V},     // printable stored
      '{sctm_pkg::OP_CHAR, 8'h00, 4'd0,  5'd0,  1'b1, FILL_V},     // zero byte dropped
      '{sctm_pkg::OP_CHAR, 8'hFF, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h1F, 4'd0,  5'd0,  1'b1, FILL_V},     // just below printable
      '{sctm_pkg::OP_CHAR, 8'h7F, 4'd0,  5'd0,  1'b1, FILL_V},     // just above printable
      '{sctm_pkg::OP_CHAR, 8'h20, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h7E, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h23, 4'd0,  5'd0,  1'b1, UNKNOWN_V},  // empty command table
      '{sctm_pkg::OP_CHAR, 8'h23, 4'd0,  5'd0,  1'b1, FILL_V},     // delimiters only
      '{sctm_pkg::OP_CHAR, 8'h2C, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h0D, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h0A, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h23, 4'd0,  5'd0,  1'b1, FILL_V},     // comma stops the skip
      '{sctm_pkg::OP_CHAR, 8'h62, 4'd0,  5'd0,  1'b0, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h20, 4'd0,  5'd0,  1'b0, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h63, 4'd0,  5'd0,  1'b0, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h23, 4'd0,  5'd0,  1'b1, UNKNOWN_V},
      '{sctm_pkg::OP_LOAD, 8'hFF, 4'd15, 5'd31, 1'b1, FILL_V},     // table corner
      '{sctm_pkg::OP_LOAD, 8'h00, 4'd0,  5'd0,  1'b1, FILL_V},
      '{sctm_pkg::OP_LOAD, 8'h23, 4'd7,  5'd16, 1'b1, FILL_V},     // terminator as table data
      '{sctm_pkg::OP_LOAD, 8'h7E, 4'd8,  5'd15, 1'b1, FILL_V},
      '{sctm_pkg::OP_CHAR, 8'h23, 4'd0,  5'd0,  1'b1, FILL_V}      // stored terminator alone
   };

   serial_command_token_matcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  verdict_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one long receiver hold-off, sender keeps going
   initial begin : rsp_holdoff
      wait (hold_armed);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin : rsp_check
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("result with no request pending", int'(rsp_tdata), 0);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[1:0] != want.status) begin
               report_mismatch("status", int'(rsp_tdata[1:0]), int'(want.status));
            end
            if (rsp_tdata[5:2] != want.match_index) begin
               report_mismatch("match_index", int'(rsp_tdata[5:2]), int'(want.match_index));
            end
            if (want.status == sctm_pkg::STAT_MATCH) match_count++;
            if (want.status == sctm_pkg::STAT_UNKNOWN) unknown_count++;
         end
      end
   end

   // ---------------- shadow model ----------------

   function automatic void reset_model();
      foreach (line_buf[i]) line_buf[i] = '0;
      foreach (cmd_table[e, p]) cmd_table[e][p] = '0;
      wr_pos    = 0;
      term_char = TERM_RESET;
      cmd_count = 0;
   endfunction

   function automatic bit is_sep(logic [CHAR_W-1:0] c);
      return c == term_char || c == sctm_pkg::CH_SPACE || c == sctm_pkg::CH_COMMA ||
             c == sctm_pkg::CH_LF || c == sctm_pkg::CH_CR;
   endfunction

   // leading skip ignores comma
   function automatic bit is_skip(logic [CHAR_W-1:0] c);
      return c == sctm_pkg::CH_SPACE || c == term_char || c == sctm_pkg::CH_LF ||
             c == sctm_pkg::CH_CR;
   endfunction

   function automatic void append_char(logic [CHAR_W-1:0] c);
      line_buf[wr_pos] = c;
      wr_pos++;
      if (wr_pos < LINE_LEN) line_buf[wr_pos] = '0;
      else wr_pos = 0;
   endfunction

   // token [first, stop) against one table entry
   function automatic bit token_equals(int ent, int first, int stop);
      logic [CHAR_W-1:0] a, b;
      for (int i = 0; i < LINE_LEN; i++) begin
         a = (first + i < stop) ? line_buf[first + i] : '0;
         b = (i < ENTRY_LEN) ? cmd_table[ent][i] : '0;
         if (a != b) return 1'b0;
         if (a == 0) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic verdict_type predict_verdict(logic op, logic [CHAR_W-1:0] ch,
                                                   logic [CMD_AW-1:0] ent,
                                                   logic [ENTRY_AW-1:0] pos);
      verdict_type v;
      int len, skip, first, stop, n_ent;
      v = FILL_V;
      if (op == sctm_pkg::OP_LOAD) begin
         cmd_table[ent][pos] = ch;
         return v;
      end
      // terminator: scan the line and look up the first token
      if (ch == term_char) begin
         len = 0;
         while (len < LINE_LEN && line_buf[len] != 0) len++;
         skip = 0;
         while (skip < len && is_skip(line_buf[skip])) skip++;
         first = 0;
         while (first < len && is_sep(line_buf[first])) first++;
         if (first == len) begin
            wr_pos = (skip >= LINE_LEN) ? 0 : skip;
            return v;
         end
         stop = first;
         while (stop < len && !is_sep(line_buf[stop])) stop++;
         n_ent = (cmd_count < MAX_COMMANDS) ? cmd_count : MAX_COMMANDS;
         v.status = sctm_pkg::STAT_UNKNOWN;
         for (int i = 0; i < n_ent; i++) begin
            if (token_equals(i, first, stop)) begin
               v.status      = sctm_pkg::STAT_MATCH;
               v.match_index = CMD_AW'(i);
               break;
            end
         end
         foreach (line_buf[i]) line_buf[i] = '0;
         wr_pos = 0;
      end
      if (ch >= sctm_pkg::CH_FIRST && ch <= sctm_pkg::CH_LAST) append_char(ch);
      return v;
   endfunction

   // ---------------- drivers ----------------

   task automatic send_request(logic op, logic [CHAR_W-1:0] ch, logic [CMD_AW-1:0] ent,
                               logic [ENTRY_AW-1:0] pos, logic known, verdict_type want);
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, pos, ent, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v = predict_verdict(op, ch, ent, pos);
      verdict_q.push_back(known ? want : v);
      request_count++;
   endtask

   task automatic send_char(logic [CHAR_W-1:0] ch);
      send_request(sctm_pkg::OP_CHAR, ch, '0, '0, 1'b0, FILL_V);
   endtask

   task automatic send_load(logic [CMD_AW-1:0] ent, logic [ENTRY_AW-1:0] pos,
                            logic [CHAR_W-1:0] ch);
      send_request(sctm_pkg::OP_LOAD, ch, ent, pos, 1'b0, FILL_V);
   endtask

   // drop valid and wait until every result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
   endtask

   task automatic set_config(logic [7:0] term, logic [7:0] count);
      csr_we    <= 1'b1;
      csr_addr  <= sctm_pkg::CSR_TERMINATOR;
      csr_wdata <= term;
      @(posedge clock);
      term_char = term;
      csr_addr  <= sctm_pkg::CSR_COMMAND_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      cmd_count = 32'(count[COUNT_W-1:0]);
      csr_we    <= 1'b0;
   endtask

   // small alphabet gives shared prefixes
   function automatic logic [CHAR_W-1:0] rand_letter();
      if ($urandom_range(3) == 0) begin
         return CHAR_W'($urandom_range(sctm_pkg::CH_FIRST, sctm_pkg::CH_LAST));
      end
      return CHAR_W'(32'h61 + $urandom_range(0, 3));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_separator();
      case ($urandom_range(3))
         0:       return sctm_pkg::CH_SPACE;
         1:       return sctm_pkg::CH_COMMA;
         2:       return sctm_pkg::CH_LF;
         default: return sctm_pkg::CH_CR;
      endcase
   endfunction

   // write a command word, zero-ended unless it fills the entry; full also fills the tail with junk
   task automatic load_word(int ent, bit full);
      int wlen, last;
      logic [CHAR_W-1:0] c;
      wlen = (ent == 3) ? ENTRY_LEN : ((ent == 4) ? 0 : int'($urandom_range(1, 6)));
      last = full ? ENTRY_LEN - 1 : ((wlen < ENTRY_LEN) ? wlen : ENTRY_LEN - 1);
      for (int p = 0; p <= last; p++) begin
         if (p < wlen) c = rand_letter();
         else if (p == wlen) c = '0;
         else c = CHAR_W'($urandom_range(0, 255));
         send_load(CMD_AW'(ent), ENTRY_AW'(p), c);
      end
   endtask

   // one command line: leading separators, token, maybe arguments, terminator
   task automatic send_command_line();
      logic [CHAR_W-1:0] chars [$];
      int kind, pick, n_ent;
      kind  = int'($urandom_range(99));
      n_ent = (cmd_count < MAX_COMMANDS) ? cmd_count : MAX_COMMANDS;
      repeat ($urandom_range(0, 2)) chars.push_back(pick_separator());
      if (kind < 8) begin
         // overlong line, write position wraps
         repeat ($urandom_range(33, 45)) chars.push_back(rand_letter());
      end else if (kind < 16) begin
         // separators only
         chars.push_back(pick_separator());
      end else if (kind < 30) begin
         repeat ($urandom_range(1, 5)) chars.push_back(rand_letter());
      end else begin
         // a table word, sometimes damaged or extended
         if (n_ent != 0 && $urandom_range(3) != 0) pick = int'($urandom_range(0, n_ent - 1));
         else pick = int'($urandom_range(0, MAX_COMMANDS - 1));
         for (int i = 0; i < ENTRY_LEN && cmd_table[pick][i] != 0; i++) begin
            chars.push_back(cmd_table[pick][i]);
         end
         if (kind < 40 && chars.size() != 0) begin
            chars[$urandom_range(0, chars.size() - 1)] = rand_letter();
         end else if (kind < 45) begin
            chars.push_back(rand_letter());
         end
      end
      // stray byte
      if ($urandom_range(9) == 0) chars.push_back(CHAR_W'($urandom_range(0, 255)));
      if ($urandom_range(3) == 0) begin
         chars.push_back(pick_separator());
         repeat ($urandom_range(1, 4)) chars.push_back(rand_letter());
      end
      chars.push_back(term_char);
      foreach (chars[i]) send_char(chars[i]);
   endtask

   // ---------------- stimulus ----------------

   initial begin : stimulus
      int  phase_start;
      int  r;
      bit  paused;
      paused = 1'b0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 73;

      // directed requests
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].ent,
                      directed_rows[i].pos, directed_rows[i].known, directed_rows[i].want);
      end

      // fill every table entry before any lookup can read it
      for (int e = 0; e < MAX_COMMANDS; e++) load_word(e, 1'b1);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         set_config(phase_term[ph], phase_count[ph]);
         if (ph == 2) begin
            send_idle_pct = 73;
            recv_idle_pct = 13;
         end
         if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_armed    = 1'b1;
         end
         phase_start = request_count;
         while (request_count - phase_start < PHASE_ITEMS) begin
            // one pause with the pipe empty
            if (ph == 2 && !paused && request_count - phase_start >= PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            r = int'($urandom_range(99));
            if (r < 85) send_command_line();
            else if (r < 93) load_word(int'($urandom_range(0, MAX_COMMANDS - 1)), 1'b0);
            else send_load(CMD_AW'($urandom_range(0, 15)), ENTRY_AW'($urandom_range(0, 31)),
                           CHAR_W'($urandom_range(0, 255)));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d terminator and table-size settings", request_count,
               N_PHASES + 1);
      $display("%0d lines matched a command, %0d lines unknown", match_count, unknown_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
